[src/pds_pkg.sv]
// ----------------------------------------------------------------------------
// PLL divider solver package
// Shared constants, command/status types and error codes.
// ----------------------------------------------------------------------------
`default_nettype none
package pds_pkg;
  localparam int PREDIV_MAX_DEF = 32;
  localparam int DIV_W = 49;            // dividend width (vco << 16)
  localparam int DVS_W = 33;            // divisor width

  localparam logic [32:0] ONE_GHZ     = 33'd1000000000;
  localparam logic [32:0] TWO_GHZ     = 33'd2000000000;
  localparam logic [32:0] FOUR_GHZ    = 33'd4000000000;
  localparam logic [32:0] VCO_MIN     = 33'd2500000000;
  localparam logic [32:0] VCO_R1_TOP  = 33'd3750000000;
  localparam logic [32:0] VCO_R23_TOP = 33'd5000000000;
  localparam logic [32:0] VCO_MAX     = 33'd6000000000;
  localparam logic [32:0] MINT_LOW    = 33'd16;
  localparam logic [32:0] MINT_HIGH   = 33'd1039;
  localparam logic [32:0] PR_LIMIT    = 33'd64;

  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_PREDIV  = 3'd1;
  localparam logic [2:0] ERR_MINT    = 3'd2;
  localparam logic [2:0] ERR_VCO     = 3'd3;
  localparam logic [2:0] ERR_DIVOVF  = 3'd4;
  localparam logic [2:0] ERR_TOOFAST = 3'd5;

  localparam logic [1:0] ADDR_REF   = 2'd0;
  localparam logic [1:0] ADDR_ASYNC = 2'd1;

  // datapath commands from the controller
  typedef struct packed {
    logic load;       // capture input item
    logic div_start;  // start one division
    logic div_sel;    // 0: ref/prediv, 1: feedback or pr division
    logic fb_sel;     // with div_sel: 0 feedback, 1 pr
    logic q_save;     // latch ref/prediv quotient
    logic p_inc;      // advance prediv
    logic out_init;   // set base post-divide
    logic dbl;        // double post-divide
    logic fb_save;    // latch feedback result
    logic pr_save;    // latch pr result
    logic fin;        // build result
  } pds_cmd_t;

  typedef struct packed {
    logic div_done;
    logic q_zero;
    logic fb_ok;      // integer part >= 16
    logic p_last;
    logic out_off;
    logic too_fast;
    logic out_zero;
    logic pr_ok;
    logic dbl_ovf;
  } pds_sts_t;
endpackage
`default_nettype wire

[src/pll_divider_solver.sv]
// Each item needs divisions through the shared radix-2 divider:
// up to 32 prediv trials (two divisions each) plus up to 6 output divisions,
// and only one item is in flight at a time.
// A finished result waits in the output register while the next item is taken.
// Synchronous active-low reset clears control state and loads register defaults.
// ----------------------------------------------------------------------------
// PLL divider solver top level
// Stream in/out, APB configuration, controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module pll_divider_solver #(
  parameter int PREDIV_MAX = pds_pkg::PREDIV_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,  // vco_hz[32:0] out_hz[65:33] out_off[66] which_output[67]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata, // prediv_code mint_code mfrac vco_range post_div_code pr_code
                                      // out_select error_code, low to high
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [30:0] ref_r;
  logic        async_r;
  logic        wr;
  logic [3:0]  cfg_addr;
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_addr = {1'b0, cfg_paddr};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= 31'd25000000; async_r <= 1'b0;
    end else if (wr) begin
      if (cfg_addr == {pds_pkg::ADDR_REF, 2'b00}) ref_r <= cfg_pwdata[30:0];
      if (cfg_addr == {pds_pkg::ADDR_ASYNC, 2'b00}) async_r <= cfg_pwdata[0];
    end
  end
  always_comb begin
    if (cfg_addr == {pds_pkg::ADDR_REF, 2'b00}) cfg_prdata = {1'b0, ref_r};
    else if (cfg_addr == {pds_pkg::ADDR_ASYNC, 2'b00}) cfg_prdata = {31'd0, async_r};
    else cfg_prdata = '0;
  end

  pds_pkg::pds_cmd_t cmd;
  pds_pkg::pds_sts_t sts;
  logic [71:0] res;

  pds_ctrl u_ctrl (.clk, .rst_n, .in_fire(in_tvalid && in_tready), .in_ready(in_tready),
                   .out_valid(out_tvalid), .out_ready(out_tready), .sts, .cmd);

  pds_datapath #(.PREDIV_MAX(PREDIV_MAX)) u_dp (
    .clk, .rst_n, .cmd, .sts, .ref_clock_hz(ref_r), .async_enable(async_r),
    .vco_hz(in_tdata[32:0]), .out_hz(in_tdata[65:33]), .out_off(in_tdata[66]),
    .which_output(in_tdata[67]), .result(res));

  // pack to output order
  assign out_tdata = {1'b0, res[2:0], res[3], res[9:4], res[13:10], res[15:14], res[31:16],
                      res[41:32], res[46:42]};
  logic unused;
  assign unused = ^{in_tdata[71:68], res[71:47]};
endmodule
`default_nettype wire

[src/pds_div.sv]
// ----------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
`default_nettype none
module pds_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [pds_pkg::DIV_W-1:0]  dividend,
  input  wire logic [pds_pkg::DVS_W-1:0]  divisor,
  output logic                            done,
  output logic [pds_pkg::DIV_W-1:0]       quotient
);
  localparam int CW = $clog2(pds_pkg::DIV_W + 1);
  logic [pds_pkg::DIV_W-1:0] q_r, q_nxt;
  logic [pds_pkg::DVS_W:0]   rem_r, rem_nxt;
  logic [pds_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt, done_r, done_nxt;
  logic [pds_pkg::DVS_W:0]   trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[pds_pkg::DVS_W-1:0], q_r[pds_pkg::DIV_W-1]};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; dvs_nxt = divisor;
      cnt_nxt = CW'(pds_pkg::DIV_W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next dividend bit and try subtract
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt = {q_r[pds_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[pds_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

[src/pds_datapath.sv]
// ----------------------------------------------------------------------------
// Solver datapath
// Operand registers, shared divider and result assembly.
// ----------------------------------------------------------------------------
`default_nettype none
module pds_datapath #(
  parameter int PREDIV_MAX = pds_pkg::PREDIV_MAX_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pds_pkg::pds_cmd_t cmd,
  output pds_pkg::pds_sts_t      sts,
  input  wire logic [30:0]       ref_clock_hz,
  input  wire logic              async_enable,
  input  wire logic [32:0]       vco_hz,
  input  wire logic [32:0]       out_hz,
  input  wire logic              out_off,
  input  wire logic              which_output,
  output logic [71:0]            result
);
  localparam int PW = $clog2(PREDIV_MAX + 1);
  logic [32:0] vco_r, ohz_r;
  logic        off_r, sel_r;
  logic [PW-1:0] p_r;
  logic [30:0] q_r;
  logic [32:0] mint_r;
  logic [15:0] frac_r;
  logic [32:0] f_r;
  logic [6:0]  div_r;
  logic [1:0]  d32_r, d10_r;
  logic [32:0] pr_r;
  logic        err_pre_r, err_mint_r, err_fast_r, err_ovf_r;
  logic [71:0] res_r;

  logic [pds_pkg::DIV_W-1:0] dnd, quo;
  logic [pds_pkg::DVS_W-1:0] dvs;
  logic done;

  always_comb begin
    if (!cmd.div_sel) begin
      dnd = {18'd0, ref_clock_hz}; dvs = pds_pkg::DVS_W'(p_r);
    end else if (!cmd.fb_sel) begin
      dnd = {vco_r, 16'd0}; dvs = {2'd0, q_r};
    end else begin
      // ceil(f/out) as (f+out-1)/out; out never 0 here
      dnd = pds_pkg::DIV_W'({1'b0, f_r} + {1'b0, ohz_r} - 34'd1);
      dvs = ohz_r;
    end
  end

  pds_div u_div (.clk, .rst_n, .start(cmd.div_start), .dividend(dnd),
                 .divisor(dvs), .done, .quotient(quo));

  logic [32:0] pr_fix;
  logic [1:0]  range;
  logic [2:0]  err;
  assign pr_fix = (pr_r == 33'd0) ? 33'd1 : pr_r;

  always_comb begin
    if (vco_r <= pds_pkg::VCO_R1_TOP)       range = 2'd0;
    else if (vco_r <= pds_pkg::FOUR_GHZ)    range = 2'd1;
    else if (vco_r <= pds_pkg::VCO_R23_TOP) range = 2'd2;
    else                                    range = 2'd3;
    priority if (err_pre_r)  err = pds_pkg::ERR_PREDIV;
    else if (err_mint_r)     err = pds_pkg::ERR_MINT;
    else if (err_fast_r)     err = pds_pkg::ERR_TOOFAST;
    else if (err_ovf_r)      err = pds_pkg::ERR_DIVOVF;
    else if (vco_r < pds_pkg::VCO_MIN || vco_r > pds_pkg::VCO_MAX)
      err = pds_pkg::ERR_VCO;
    else err = pds_pkg::ERR_OK;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vco_r <= vco_hz; ohz_r <= out_hz; off_r <= out_off; sel_r <= which_output;
      p_r <= PW'(1); err_pre_r <= 1'b0; err_mint_r <= 1'b0;
      err_fast_r <= 1'b0; err_ovf_r <= 1'b0;
    end
    if (cmd.q_save) q_r <= quo[30:0];
    if (cmd.p_inc) begin
      if (p_r == PW'(PREDIV_MAX)) err_pre_r <= 1'b1;
      p_r <= p_r + 1'b1;
    end
    if (cmd.fb_save) begin
      if (q_r == 31'd0) begin
        mint_r <= pds_pkg::MINT_HIGH + 33'd1; frac_r <= '0;
      end else begin
        mint_r <= quo[48:16]; frac_r <= quo[15:0];
      end
    end
    if (cmd.out_init) begin
      if (mint_r > pds_pkg::MINT_HIGH) err_mint_r <= 1'b1;
      if (ohz_r > pds_pkg::ONE_GHZ) begin
        // a disabled output never takes the fast path check
        if (!async_enable && !off_r) err_fast_r <= 1'b1;
        d32_r <= 2'd0; div_r <= 7'd2; f_r <= vco_r >> 1;
      end else if (vco_r <= pds_pkg::TWO_GHZ) begin
        d32_r <= 2'd0; div_r <= 7'd2; f_r <= vco_r >> 1;
      end else if (vco_r <= pds_pkg::FOUR_GHZ) begin
        d32_r <= 2'd2; div_r <= 7'd4; f_r <= vco_r >> 2;
      end else begin
        d32_r <= 2'd3; div_r <= 7'd8; f_r <= vco_r >> 3;
      end
      d10_r <= 2'd0;
    end
    if (cmd.pr_save) pr_r <= quo[32:0];
    if (cmd.dbl) begin
      if (div_r < 7'd8) d32_r <= (d32_r != 2'd0) ? 2'd3 : 2'd2;
      else if (div_r < 7'd64) d10_r <= d10_r + 2'd1;
      else err_ovf_r <= 1'b1;
      div_r <= {div_r[5:0], 1'b0};
      f_r <= f_r >> 1;
    end
    if (cmd.fin) begin
      if (err != pds_pkg::ERR_OK)
        res_r <= {38'd0, 30'd0, sel_r, err};
      else
        res_r <= {25'd0, 5'(p_r - 1'b1), 10'(mint_r - pds_pkg::MINT_LOW), frac_r,
                  range, off_r ? 4'hF : {d32_r, d10_r},
                  off_r ? 6'h3F : 6'(pr_fix - 33'd1), sel_r, err};
    end
  end

  // result layout: err[2:0] sel[3] pr[9:4] pdc[13:10] rng[15:14] frac[31:16]
  // mint[41:32] prediv[46:42]
  assign result = {25'd0, res_r[46:0]};

  assign sts.div_done = done;
  assign sts.q_zero   = (q_r == 31'd0);
  assign sts.fb_ok    = (quo[48:16] >= pds_pkg::MINT_LOW);
  assign sts.p_last   = (p_r == PW'(PREDIV_MAX));
  assign sts.out_off  = off_r;
  assign sts.too_fast = (ohz_r > pds_pkg::ONE_GHZ) && !async_enable;
  assign sts.out_zero = (ohz_r == 33'd0);
  assign sts.pr_ok    = (quo[32:0] <= pds_pkg::PR_LIMIT) && (quo[48:33] == '0);
  assign sts.dbl_ovf  = (div_r >= 7'd64);

  logic unused;
  assign unused = ^{rst_n, res_r[71:47]};
endmodule
`default_nettype wire

[src/pds_ctrl.sv]
// ----------------------------------------------------------------------------
// Solver controller
// Sequences prediv search, feedback ratio and output divider search.
// ----------------------------------------------------------------------------
`default_nettype none
module pds_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire pds_pkg::pds_sts_t sts,
  output pds_pkg::pds_cmd_t      cmd
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_QDIV = 9'b000000010, S_QW = 9'b000000100,
    S_FDIV = 9'b000001000, S_FW = 9'b000010000, S_OINIT = 9'b000100000,
    S_PDIV = 9'b001000000, S_PW = 9'b010000000, S_FIN = 9'b100000000
  } st_t;
  st_t st_r, st_nxt;
  logic ov_r, ov_nxt, err_r, err_nxt;

  always_comb begin
    st_nxt = st_r; cmd = '0; err_nxt = err_r;
    ov_nxt = ov_r && !out_ready;
    unique case (st_r)
      S_IDLE: if (in_fire) begin cmd.load = 1'b1; st_nxt = S_QDIV; err_nxt = 1'b0; end
      S_QDIV: begin cmd.div_start = 1'b1; st_nxt = S_QW; end
      S_QW: if (sts.div_done) begin cmd.q_save = 1'b1; st_nxt = S_FDIV; end
      S_FDIV: begin
        if (sts.q_zero) begin cmd.fb_save = 1'b1; st_nxt = S_OINIT; end
        else begin cmd.div_start = 1'b1; cmd.div_sel = 1'b1; st_nxt = S_FW; end
      end
      S_FW: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) begin
          if (sts.fb_ok) begin cmd.fb_save = 1'b1; st_nxt = S_OINIT; end
          else begin
            cmd.p_inc = 1'b1;
            if (sts.p_last) begin err_nxt = 1'b1; st_nxt = S_FIN; end
            else st_nxt = S_QDIV;
          end
        end
      end
      S_OINIT: begin
        cmd.out_init = 1'b1;
        if (sts.out_off || sts.too_fast) st_nxt = S_FIN;
        else st_nxt = S_PDIV;
      end
      S_PDIV: begin
        if (sts.out_zero) begin
          cmd.dbl = 1'b1;
          if (sts.dbl_ovf) st_nxt = S_FIN;
        end else begin
          cmd.div_start = 1'b1; cmd.div_sel = 1'b1; cmd.fb_sel = 1'b1; st_nxt = S_PW;
        end
      end
      S_PW: begin
        cmd.div_sel = 1'b1; cmd.fb_sel = 1'b1;
        if (sts.div_done) begin
          cmd.pr_save = 1'b1;
          if (sts.pr_ok) st_nxt = S_FIN;
          else begin
            cmd.dbl = 1'b1;
            st_nxt = sts.dbl_ovf ? S_FIN : S_PDIV;
          end
        end
      end
      S_FIN: if (!ov_r || out_ready) begin cmd.fin = 1'b1; ov_nxt = 1'b1; st_nxt = S_IDLE; end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; err_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; err_r <= err_nxt;
    end
  end

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = ov_r;

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> st_r == S_IDLE) else $error("load outside idle");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid) else $error("result not presented");
endmodule
`default_nettype wire

[bench/pll_divider_solver_test.sv]
// ----------------------------------------------------------------------------
// PLL divider solver testbench
// Drives requests on the input stream and register writes over APB. Every
// returned result is compared field by field with an in-bench solver model.
// Directed table, async and ref-clock cases, a receiver stall, then random phases with gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pll_divider_solver_test;

  typedef struct packed {
    logic [2:0]  err;
    logic        sel;
    logic [5:0]  pr;
    logic [3:0]  pdc;
    logic [1:0]  range;
    logic [15:0] frac;
    logic [9:0]  mint;
    logic [4:0]  prediv;
  } solution_t;

  typedef struct {
    logic [32:0] vco;
    logic [32:0] ohz;
    logic        off;
    logic        sel;
    logic        has_fixed;
    solution_t   fixed;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [71:0] in_tdata = '0;   // vco_hz, out_hz, out_off, which_output, low to high
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;       // prediv, mint, mfrac, vco_range, post_div, pr, select, error
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  pll_divider_solver dut (.*);

  always #2 clk = ~clk;

  logic [30:0] ref_hz_reg;
  logic        async_reg;
  solution_t   pending_q[$];
  int          fail_count = 0;
  int          hold_off = 0;
  int          gap_left = 0;
  bit          rx_random = 1'b1;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic logic [2:0] solve_post_div(input logic [32:0] vco,
      input logic [32:0] ohz, output logic [3:0] pdc, output logic [5:0] prc);
    logic [63:0] dv, f, pr;
    logic [1:0] d32, d10;
    d10 = 2'd0;
    if (ohz > pds_pkg::ONE_GHZ) begin
      if (!async_reg) return pds_pkg::ERR_TOOFAST;
      d32 = 2'd0; dv = 64'd2;
    end else if (vco <= pds_pkg::TWO_GHZ) begin
      d32 = 2'd0; dv = 64'd2;
    end else if (vco <= pds_pkg::FOUR_GHZ) begin
      d32 = 2'd2; dv = 64'd4;
    end else begin
      d32 = 2'd3; dv = 64'd8;
    end
    f = vco / dv;
    forever begin
      if (ohz != 0) begin
        pr = (f + ohz - 64'd1) / ohz;
        if (pr <= 64'd64) begin
          if (pr == 0) pr = 64'd1;
          pdc = {d32, d10};
          prc = 6'(pr - 64'd1);
          return pds_pkg::ERR_OK;
        end
      end
      if (dv < 8) d32 = (d32 != 2'd0) ? 2'd3 : 2'd2;
      else if (dv < 64) d10++;
      else return pds_pkg::ERR_DIVOVF;
      dv <<= 1;
      f >>= 1;
    end
  endfunction

  function automatic solution_t solve_pll(input request_t r);
    solution_t s;
    logic [63:0] q, fb, mint, frac;
    logic [2:0] err;
    logic [3:0] pdc;
    logic [5:0] prc;
    logic [1:0] range;
    int p;
    bit found;
    found = 0; p = 0; mint = 0; frac = 0; pdc = 4'hf; prc = 6'h3f; range = 2'd0;
    for (int i = 1; i <= 32 && !found; i++) begin
      q = ref_hz_reg / i;
      if (q == 0) begin
        p = i; mint = 64'd1040; found = 1;
      end else begin
        fb = {r.vco, 16'h0} / q;
        if ((fb >> 16) >= 16) begin
          p = i; mint = fb >> 16; frac = {48'd0, fb[15:0]}; found = 1;
        end
      end
    end
    if (!found) err = pds_pkg::ERR_PREDIV;
    else if (mint > 1039) err = pds_pkg::ERR_MINT;
    else err = pds_pkg::ERR_OK;
    if (err == pds_pkg::ERR_OK && !r.off) err = solve_post_div(r.vco, r.ohz, pdc, prc);
    if (err == pds_pkg::ERR_OK) begin
      if (r.vco < pds_pkg::VCO_MIN || r.vco > pds_pkg::VCO_MAX) err = pds_pkg::ERR_VCO;
      else if (r.vco <= pds_pkg::VCO_R1_TOP) range = 2'd0;
      else if (r.vco <= pds_pkg::FOUR_GHZ) range = 2'd1;
      else if (r.vco <= pds_pkg::VCO_R23_TOP) range = 2'd2;
      else range = 2'd3;
    end
    s = '0;
    if (err == pds_pkg::ERR_OK) begin
      s.prediv = 5'(p - 1); s.mint = 10'(mint - 64'd16); s.frac = frac[15:0];
      s.range = range; s.pdc = pdc; s.pr = prc;
    end
    s.sel = r.sel;
    s.err = err;
    return s;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= 3'({idx, 2'b00}); cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (idx == pds_pkg::ADDR_REF) ref_hz_reg = value[30:0];
    else async_reg = value[0];
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  task automatic send_request(input request_t r, input bit gaps);
    solution_t want;
    want = solve_pll(r);
    if (r.has_fixed && want != r.fixed)
      report_mismatch("table row vs solver", 64'(want), 64'(r.fixed));
    pending_q.push_back(want);
    in_tdata <= {4'b0, r.sel, r.off, r.ohz, r.vco};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (gaps && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(20, 200))
        @(posedge clk);
    end
  endtask

  function automatic request_t make_request(input bit good);
    request_t r;
    r.has_fixed = 0;
    r.fixed = '0;
    r.sel = 1'($urandom_range(0, 1));
    r.off = ($urandom_range(0, 7) == 0);
    if (good) begin
      r.vco = 33'd2400000000 + 33'($urandom_range(0, 3700000000));
      case ($urandom_range(0, 3))
        0: r.ohz = 33'($urandom_range(1, 1000));
        1: r.ohz = 33'($urandom_range(1000, 50000000));
        2: r.ohz = 33'($urandom_range(50000000, 1000000000));
        default: r.ohz = 33'd900000000 + 33'($urandom_range(0, 2000000000));
      endcase
    end else begin
      r.vco = 33'({$urandom_range(0, 1), $urandom()} >> $urandom_range(0, 32));
      r.ohz = 33'({$urandom_range(0, 1), $urandom()} >> $urandom_range(0, 32));
    end
    return r;
  endfunction

  localparam int N_ROWS = 14;
  request_t table_rows[N_ROWS];

  function automatic request_t row(input logic [32:0] vco, input logic [32:0] ohz,
      input logic off, input logic sel, input bit fixed, input logic [2:0] err);
    request_t r;
    r.vco = vco; r.ohz = ohz; r.off = off; r.sel = sel;
    r.has_fixed = fixed;
    r.fixed = '0;
    r.fixed.sel = sel;
    r.fixed.err = err;
    return r;
  endfunction

  initial begin
    ref_hz_reg = 31'd25000000;
    async_reg = 1'b0;
    table_rows[0]  = row(33'd0, 33'd1, 0, 0, 1, pds_pkg::ERR_PREDIV);
    table_rows[1]  = row(33'h1ffffffff, 33'h1ffffffff, 0, 1, 1, pds_pkg::ERR_TOOFAST);
    table_rows[2]  = row(33'd3000000000, 33'd2000000000, 0, 0, 1, pds_pkg::ERR_TOOFAST);
    table_rows[3]  = row(33'd3000000000, 33'd0, 0, 1, 1, pds_pkg::ERR_DIVOVF);
    table_rows[4]  = row(33'd3000000000, 33'd1, 0, 0, 1, pds_pkg::ERR_DIVOVF);
    table_rows[5]  = row(33'd7000000000, 33'd100000000, 0, 1, 1, pds_pkg::ERR_VCO);
    table_rows[6]  = row(33'd2000000000, 33'd100000000, 0, 0, 1, pds_pkg::ERR_VCO);
    table_rows[7]  = row(33'd3000000000, 33'd100000000, 1, 1, 0, pds_pkg::ERR_OK);
    table_rows[8]  = row(33'd2500000000, 33'd100000000, 0, 0, 0, pds_pkg::ERR_OK);
    table_rows[9]  = row(33'd3750000000, 33'd400000000, 0, 1, 0, pds_pkg::ERR_OK);
    table_rows[10] = row(33'd4000000000, 33'd1000000000, 0, 0, 0, pds_pkg::ERR_OK);
    table_rows[11] = row(33'd5000000000, 33'd1000000, 0, 1, 0, pds_pkg::ERR_OK);
    table_rows[12] = row(33'd6000000000, 33'd10000000, 0, 0, 0, pds_pkg::ERR_OK);
    table_rows[13] = row(33'd400, 33'd1, 0, 1, 0, pds_pkg::ERR_OK);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_ROWS; i++) send_request(table_rows[i], 1);
    in_tvalid <= 1'b0;
    wait_drained();

    // Async path on, extreme reference clocks.
    cfg_write(pds_pkg::ADDR_ASYNC, 32'd1);
    send_request(row(33'd3000000000, 33'd1500000000, 0, 1, 0, pds_pkg::ERR_OK), 0);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_write(pds_pkg::ADDR_REF, 32'd1);
    send_request(row(33'd3000000000, 33'd100000000, 0, 0, 1, pds_pkg::ERR_MINT), 0);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_write(pds_pkg::ADDR_REF, 32'h7fffffff);
    send_request(row(33'd3000000000, 33'd100000000, 0, 1, 0, pds_pkg::ERR_OK), 0);
    send_request(row(33'd20, 33'd1, 0, 0, 1, pds_pkg::ERR_PREDIV), 0);
    in_tvalid <= 1'b0;
    wait_drained();

    // Long receiver stall while the sender keeps offering.
    cfg_write(pds_pkg::ADDR_REF, 32'd25000000);
    cfg_write(pds_pkg::ADDR_ASYNC, 32'd0);
    rx_random = 1'b0;
    hold_off = 3000;
    for (int i = 0; i < 4; i++) send_request(make_request(1), 0);
    in_tvalid <= 1'b0;
    rx_random = 1'b1;
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: cfg_write(pds_pkg::ADDR_REF, 32'd1 + 32'($urandom_range(0, 200000000)));
        1: cfg_write(pds_pkg::ADDR_REF, 32'd10000000 + 32'($urandom_range(0, 100000000)));
        2: cfg_write(pds_pkg::ADDR_REF, $urandom() & 32'h7fffffff);
        default: cfg_write(pds_pkg::ADDR_REF, 32'd25000000);
      endcase
      cfg_write(pds_pkg::ADDR_ASYNC, 32'($urandom_range(0, 1)));
      for (int i = 0; i < 100; i++)
        send_request(make_request($urandom_range(0, 4) != 0), 1);
      in_tvalid <= 1'b0;
      wait_drained();
    end

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Result side: random gaps, mostly short, plus a counted hold-off on request.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (!rx_random) begin
      out_tready <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      gap_left <= ($urandom_range(0, 9) < 8) ? int'($urandom_range(0, 2))
                                              : int'($urandom_range(20, 200));
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    solution_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = solution_t'(out_tdata[46:0]);
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(got), 64'd0);
      end else begin
        want = pending_q.pop_front();
        if (got.prediv !== want.prediv) report_mismatch("prediv_code", got.prediv, want.prediv);
        if (got.mint !== want.mint) report_mismatch("mint_code", got.mint, want.mint);
        if (got.frac !== want.frac) report_mismatch("mfrac", got.frac, want.frac);
        if (got.range !== want.range) report_mismatch("vco_range", got.range, want.range);
        if (got.pdc !== want.pdc) report_mismatch("post_div_code", got.pdc, want.pdc);
        if (got.pr !== want.pr) report_mismatch("pr_code", got.pr, want.pr);
        if (got.sel !== want.sel) report_mismatch("out_select", got.sel, want.sel);
        if (got.err !== want.err) report_mismatch("error_code", got.err, want.err);
      end
    end
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
src/pds_pkg.sv
src/pds_div.sv
src/pds_datapath.sv
src/pds_ctrl.sv
src/pll_divider_solver.sv
bench/pll_divider_solver_test.sv
